### rtl/detq_pkg.sv
// Shared types and constants for the double-ended task queue.
package detq_pkg;

   // Default number of words the ring buffer holds
   localparam int unsigned DEPTH_DEFAULT = 16;

   localparam int unsigned WORD_W   = 64;
   localparam int unsigned OPCODE_W = 3;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 5;

   // Operation codes carried in the request
   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_HEAD   = 3'd0,
      OP_PUSH_TAIL   = 3'd1,
      OP_POP_HEAD    = 3'd2,
      OP_POP_TAIL    = 3'd3,
      OP_VERIFY_HEAD = 3'd4
   } opcode_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_MISMATCH = 2'd3
   } status_type;

   // Controller states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;    // capture request, start storage read
      logic commit;  // apply operation, load result register
   } cmd_type;

endpackage

### rtl/detq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module detq_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/detq_ctrl.sv
// Controller: request/response handshake and sequencing of each operation.
module detq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output detq_pkg::cmd_type cmd
);

   detq_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                commit;

   assign accept = req_tvalid && (state_ff == detq_pkg::ST_IDLE);
   // Result slot is free if empty or being drained this cycle
   assign commit = (state_ff == detq_pkg::ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         detq_pkg::ST_IDLE: begin
            if (accept) state_in = detq_pkg::ST_EXEC;
         end
         detq_pkg::ST_EXEC: begin
            if (commit) state_in = detq_pkg::ST_IDLE;
         end
         default: state_in = detq_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_tready = (state_ff == detq_pkg::ST_IDLE);
      cmd.load   = accept;
      cmd.commit = commit;
   end

   // Result valid flag
   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= detq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/detq_dpath.sv
// Datapath: ring pointers, occupancy, word storage and result register.
module detq_dpath #(
   parameter int unsigned DEPTH = detq_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  detq_pkg::cmd_type             cmd,
   input  logic [detq_pkg::OPCODE_W-1:0] opcode,
   input  logic [detq_pkg::WORD_W-1:0]   data_value,
   input  logic [detq_pkg::WORD_W-1:0]   expected_value,
   output logic [detq_pkg::WORD_W-1:0]   popped_value,
   output logic [detq_pkg::STATUS_W-1:0] status,
   output logic [detq_pkg::COUNT_W-1:0]  entry_count
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   // Captured request
   logic [detq_pkg::OPCODE_W-1:0] op_ff;
   logic [detq_pkg::WORD_W-1:0]   data_ff;
   logic [detq_pkg::WORD_W-1:0]   expected_ff;

   // Queue state
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] occ_ff, occ_in;

   // Result register
   logic [detq_pkg::WORD_W-1:0]   popped_ff, popped_in;
   logic [detq_pkg::STATUS_W-1:0] status_ff;
   logic [detq_pkg::COUNT_W-1:0]  count_ff;
   detq_pkg::status_type          status_in;

   logic [IDX_W-1:0]            head_next, head_prev, tail_next, tail_prev;
   logic                        is_full, is_empty;
   logic [IDX_W-1:0]            rd_addr;
   logic [IDX_W-1:0]            wr_addr;
   logic                        wr_en;
   logic [detq_pkg::WORD_W-1:0] rd_data;
   logic [CNT_W+detq_pkg::COUNT_W-1:0] occ_wide;

   // Ring neighbors
   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign head_prev = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign tail_next = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? LAST_IDX : tail_ff - 1'b1;

   assign is_full  = (occ_ff == FULL_CNT);
   assign is_empty = (occ_ff == '0);

   // Read the word a pop would remove, as the request is taken
   assign rd_addr = (detq_pkg::opcode_type'(opcode) == detq_pkg::OP_POP_TAIL) ?
                    tail_prev : head_ff;

   // Operation decode at commit
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      occ_in    = occ_ff;
      popped_in = '0;
      status_in = detq_pkg::STAT_OK;
      wr_en     = 1'b0;
      wr_addr   = tail_ff;
      unique case (detq_pkg::opcode_type'(op_ff))
         detq_pkg::OP_PUSH_HEAD: begin
            if (is_full) begin
               status_in = detq_pkg::STAT_FULL;
            end else begin
               wr_en   = 1'b1;
               wr_addr = head_prev;
               head_in = head_prev;
               occ_in  = occ_ff + 1'b1;
            end
         end
         detq_pkg::OP_PUSH_TAIL: begin
            if (is_full) begin
               status_in = detq_pkg::STAT_FULL;
            end else begin
               wr_en   = 1'b1;
               wr_addr = tail_ff;
               tail_in = tail_next;
               occ_in  = occ_ff + 1'b1;
            end
         end
         detq_pkg::OP_POP_HEAD, detq_pkg::OP_VERIFY_HEAD: begin
            if (is_empty) begin
               status_in = detq_pkg::STAT_EMPTY;
            end else if ((detq_pkg::opcode_type'(op_ff) == detq_pkg::OP_VERIFY_HEAD) &&
                         (rd_data != expected_ff)) begin
               status_in = detq_pkg::STAT_MISMATCH;
            end else begin
               popped_in = rd_data;
               head_in   = head_next;
               occ_in    = occ_ff - 1'b1;
            end
         end
         detq_pkg::OP_POP_TAIL: begin
            if (is_empty) begin
               status_in = detq_pkg::STAT_EMPTY;
            end else begin
               popped_in = rd_data;
               tail_in   = tail_prev;
               occ_in    = occ_ff - 1'b1;
            end
         end
         default: begin
            // unused opcodes: no operation
         end
      endcase
   end

   // Count reported in five bits
   assign occ_wide = {{detq_pkg::COUNT_W{1'b0}}, occ_in};

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= opcode;
         data_ff     <= data_value;
         expected_ff <= expected_value;
      end
   end

   // Pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
      end else if (cmd.commit) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         popped_ff <= popped_in;
         status_ff <= status_in;
         count_ff  <= occ_wide[detq_pkg::COUNT_W-1:0];
      end
   end

   assign popped_value = popped_ff;
   assign status       = status_ff;
   assign entry_count  = count_ff;

   // Word storage
   detq_ram #(
      .WIDTH (detq_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en && cmd.commit),
      .wr_addr (wr_addr),
      .wr_data (data_ff),
      .rd_en   (cmd.load),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

### rtl/double_ended_task_queue_unit.sv
// Top level of the double-ended task queue: handshake ports around controller and datapath.
//
// Bounded double-ended queue of 64-bit words held in a ring buffer of DEPTH entries.
// Request channel (req_): tuser carries the opcode (push head, push tail, pop head,
// pop tail, verify-pop head); tdata carries the word to push and the expected head word.
// Response channel (rsp_): exactly one response per request, in request order, with the
// removed word (zero when nothing is removed), a status in tuser and the occupancy after
// the operation.
// A taken request is captured and its storage read started in ST_IDLE; it commits in
// ST_EXEC once the output register is free, and its response is then valid.
// The storage read is registered, so each request is first captured and read, then
// committed; a new request is taken only once the previous one has committed.
// A push into a full queue is dropped with status full; pops on an empty queue report
// empty; a verify-pop whose head differs reports mismatch and leaves the queue intact.
// Reset empties the queue and drops any pending response; the stored words themselves
// are not cleared and need no clearing pass.
// When the receiver stalls, the finished response waits in the output register while
// the next request is still taken; that request commits once the register is free.
module double_ended_task_queue_unit #(
   parameter int unsigned DEPTH = detq_pkg::DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // data_value[63:0], expected_value[127:64]
   input  logic [2:0]   req_tuser,  // opcode[2:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,  // popped_value[63:0], entry_count[68:64], zero[71:69]
   output logic [1:0]   rsp_tuser   // status[1:0]
);

   detq_pkg::cmd_type             cmd;
   logic [detq_pkg::WORD_W-1:0]   popped_value;
   logic [detq_pkg::STATUS_W-1:0] status;
   logic [detq_pkg::COUNT_W-1:0]  entry_count;

   detq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   detq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .opcode         (req_tuser),
      .data_value     (req_tdata[63:0]),
      .expected_value (req_tdata[127:64]),
      .popped_value   (popped_value),
      .status         (status),
      .entry_count    (entry_count)
   );

   // Response packing
   assign rsp_tdata = {3'b000, entry_count, popped_value};
   assign rsp_tuser = status;

endmodule

### test/double_ended_task_queue_unit_tb.sv
// Self-checking testbench for the double-ended task queue: corner cases plus random traffic.
`timescale 1ns / 1ps

module double_ended_task_queue_unit_tb;
   import detq_pkg::*;

   localparam int unsigned QUEUE_DEPTH = 16;
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned PRINT_CAP = 50;

   // Opcodes outside the enum act as no-ops
   localparam logic [OPCODE_W-1:0] OP_RESERVED_5 = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_RESERVED_6 = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_RESERVED_7 = 3'd7;

   typedef struct {
      logic [WORD_W-1:0]  popped;
      status_type         status;
      logic [COUNT_W-1:0] count;
   } queue_outcome_t;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;   // data_value[63:0], expected_value[127:64]
   logic [2:0]   req_tuser;   // opcode[2:0]
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [71:0]  rsp_tdata;   // popped_value[63:0], entry_count[68:64], zero[71:69]
   logic [1:0]   rsp_tuser;   // status[1:0]

   // Shadow copy of the ring buffer
   logic [WORD_W-1:0]  ring_words [QUEUE_DEPTH];
   logic [3:0]         ring_head;
   logic [3:0]         ring_tail;
   logic [COUNT_W-1:0] ring_count;

   queue_outcome_t pending_results [$];
   int unsigned    error_count;
   int unsigned    cycle_count;
   bit             stalls_on;

   double_ended_task_queue_unit #(.DEPTH(QUEUE_DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Timeout watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  pending_results.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // Receiver backpressure
   always @(negedge clock) begin
      if (stalls_on) begin
         rsp_tready <= ($urandom_range(99) >= 26);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] want);
      if (error_count < PRINT_CAP) begin
         $display("mismatch in %s at cycle %0d: got %h, expected %h", field, cycle_count,
                  got, want);
      end
      error_count++;
   endtask

   // Response checker
   always @(posedge clock) begin
      queue_outcome_t exp_result;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata[63:0], '0);
         end else begin
            exp_result = pending_results.pop_front();
            if (rsp_tdata[63:0] !== exp_result.popped)
               report_mismatch("popped_value", rsp_tdata[63:0], exp_result.popped);
            if (rsp_tuser !== exp_result.status)
               report_mismatch("status", rsp_tuser, exp_result.status);
            if (rsp_tdata[68:64] !== exp_result.count)
               report_mismatch("entry_count", rsp_tdata[68:64], exp_result.count);
            if (rsp_tdata[71:69] !== 3'd0)
               report_mismatch("tdata padding", rsp_tdata[71:69], '0);
         end
      end
   end

   // Predict one request against the shadow ring buffer
   task automatic predict_queue_op(input logic [OPCODE_W-1:0] op,
                                   input logic [WORD_W-1:0] data,
                                   input logic [WORD_W-1:0] want,
                                   output queue_outcome_t outcome);
      outcome.popped = '0;
      outcome.status = STAT_OK;
      case (op)
         OP_PUSH_HEAD: begin
            if (ring_count >= QUEUE_DEPTH) begin
               outcome.status = STAT_FULL;
            end else begin
               ring_head = ring_head - 4'd1;
               ring_words[ring_head] = data;
               ring_count++;
            end
         end
         OP_PUSH_TAIL: begin
            if (ring_count >= QUEUE_DEPTH) begin
               outcome.status = STAT_FULL;
            end else begin
               ring_words[ring_tail] = data;
               ring_tail = ring_tail + 4'd1;
               ring_count++;
            end
         end
         OP_POP_HEAD, OP_VERIFY_HEAD: begin
            if (ring_count == 0) begin
               outcome.status = STAT_EMPTY;
            end else if (op == OP_VERIFY_HEAD && ring_words[ring_head] != want) begin
               outcome.status = STAT_MISMATCH;
            end else begin
               outcome.popped = ring_words[ring_head];
               ring_head = ring_head + 4'd1;
               ring_count--;
            end
         end
         OP_POP_TAIL: begin
            if (ring_count == 0) begin
               outcome.status = STAT_EMPTY;
            end else begin
               ring_tail = ring_tail - 4'd1;
               outcome.popped = ring_words[ring_tail];
               ring_count--;
            end
         end
         default: ;  // reserved opcodes change nothing
      endcase
      outcome.count = ring_count;
   endtask

   // Send one request; valid stays up until accepted, the next call decides what follows
   task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [WORD_W-1:0] data,
                               input logic [WORD_W-1:0] want);
      int gap = 0;
      queue_outcome_t outcome;
      if (stalls_on) begin
         while ($urandom_range(99) < 26) gap++;
      end
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {want, data};
      do @(posedge clock); while (!req_tready);
      predict_queue_op(op, data, want, outcome);
      pending_results.push_back(outcome);
   endtask

   // Drop valid and hold off until every response is back
   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] random_word();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 8) return '0;
      if (pick < 16) return '1;
      if (pick < 24) return 64'd1 << $urandom_range(63);
      return {$urandom, $urandom};
   endfunction

   // Expected word for a verify-pop: mostly the real head, sometimes near or far off
   function automatic logic [WORD_W-1:0] pick_verify_word();
      int unsigned pick;
      pick = $urandom_range(99);
      if (ring_count != 0 && pick < 65) return ring_words[ring_head];
      if (ring_count != 0 && pick < 85)
         return ring_words[ring_head] ^ (64'd1 << $urandom_range(63));
      return random_word();
   endfunction

   // Empty queue: every pop kind reports empty, reserved opcodes are no-ops
   task automatic test_empty_queue();
      send_request(OP_POP_HEAD, '1, '1);
      send_request(OP_POP_TAIL, '0, '0);
      send_request(OP_VERIFY_HEAD, '0, '0);
      send_request(OP_RESERVED_5, '1, '1);
      send_request(OP_RESERVED_7, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
   endtask

   // Fill from both ends with extreme words, then push into a full queue
   task automatic test_fill_and_overflow();
      logic [WORD_W-1:0] patterns [4];
      patterns[0] = '0;
      patterns[1] = '1;
      patterns[2] = 64'h5555_5555_5555_5555;
      patterns[3] = 64'hAAAA_AAAA_AAAA_AAAA;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         send_request((i % 2) ? OP_PUSH_HEAD : OP_PUSH_TAIL,
                      (i < 4) ? patterns[i] : {$urandom, $urandom}, '0);
      end
      send_request(OP_PUSH_HEAD, '1, '0);
      send_request(OP_PUSH_TAIL, '0, '1);
   endtask

   // Verify-pop miss and hit, then plain pops at both ends
   task automatic test_pop_kinds();
      send_request(OP_VERIFY_HEAD, '0, ~ring_words[ring_head]);
      send_request(OP_VERIFY_HEAD, '1, ring_words[ring_head]);
      send_request(OP_POP_TAIL, '0, '0);
      send_request(OP_POP_HEAD, '0, '0);
   endtask

   // Random traffic; push bias swings so the queue sweeps between empty and full
   task automatic test_random_traffic(input int unsigned num_items);
      int unsigned sent = 0;
      int unsigned push_pct = 70;
      int unsigned pick;
      logic [OPCODE_W-1:0] op;
      while (sent < num_items) begin
         if (sent % 40 == 0) push_pct = (push_pct == 70) ? 30 : 70;
         pick = $urandom_range(99);
         if (pick < 4) begin
            op = OP_RESERVED_5 + OPCODE_W'($urandom_range(2));
            send_request(op, random_word(), random_word());
         end else begin
            if ($urandom_range(99) < push_pct) begin
               op = $urandom_range(1) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
            end else begin
               pick = $urandom_range(99);
               op = (pick < 35) ? OP_POP_HEAD : (pick < 70) ? OP_POP_TAIL : OP_VERIFY_HEAD;
            end
            send_request(op, random_word(),
                         (op == OP_VERIFY_HEAD) ? pick_verify_word() : random_word());
         end
         sent++;
      end
   endtask

   // Bursts separated by full drains of the response side
   task automatic test_drain_pauses();
      for (int b = 0; b < 4; b++) begin
         test_random_traffic(50);
         wait_for_drain();
      end
   endtask

   // Back-to-back traffic with neither side idling
   task automatic test_no_idle_stretch();
      stalls_on = 1'b0;
      test_random_traffic(400);
      stalls_on = 1'b1;
   endtask

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      stalls_on   = 1'b1;
      error_count = 0;
      cycle_count = 0;
      ring_head   = '0;
      ring_tail   = '0;
      ring_count  = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) ring_words[i] = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_fill_and_overflow();
      test_pop_kinds();
      test_random_traffic(600);
      test_drain_pauses();
      test_no_idle_stretch();
      test_random_traffic(400);

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
